FILE: src/iois_pkg.sv
// ----------------------------------------------------------------------------
// iois_pkg
// Shared types and constants for the insertion-ordered integer set.
// ----------------------------------------------------------------------------
package iois_pkg;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int MCNT_W  = 7;

    typedef logic [FUNC_W-1:0]         t_func;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [MCNT_W-1:0]         t_mcnt;

    localparam t_func OP_ADD      = 2'd0;
    localparam t_func OP_REMOVE   = 2'd1;
    localparam t_func OP_CONTAINS = 2'd2;
    localparam t_func OP_CLEAR    = 2'd3;

endpackage

FILE: src/iois_ram.sv
// ----------------------------------------------------------------------------
// iois_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iois_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/insertion_ordered_int_set.sv
// ----------------------------------------------------------------------------
// insertion_ordered_int_set
// Set of distinct signed 32-bit values kept packed in order of first add.
// ----------------------------------------------------------------------------
// One transaction is accepted when start is high and busy is low; busy then
// stays high until the result. Add, remove and contains scan the members one
// per cycle through the single read port of the entry RAM. A remove that
// finds a value then moves each later member down one place, one entry per
// cycle through the same read and write ports. The result is shown on
// o_success, o_full_reject and o_member_count for exactly one cycle with
// o_valid; the receiver cannot stall it, so it must take it in that cycle.
// o_member_count is the low 7 bits of the member count.
module insertion_ordered_int_set #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  iois_pkg::t_func  i_func,
    input  iois_pkg::t_value i_value,
    output logic             o_valid,
    output logic             o_success,
    output logic             o_full_reject,
    output iois_pkg::t_mcnt  o_member_count
);

    import iois_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SRCH  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]    r_state, n_state;
    t_func         r_func, n_func;
    t_value        r_value, n_value;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_valid, n_valid;
    logic          r_ok, n_ok;
    logic          r_full, n_full;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;
    logic               hit;
    logic               more;
    logic [MCNT_W+CW-1:0] mcnt_ext;

    iois_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign hit  = r_pend && (rdata == r_value);
    assign more = (r_ptr < r_count);

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_value = r_value;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_pend  = 1'b0;
        n_pidx  = r_pidx;
        n_valid = 1'b0;
        n_ok    = r_ok;
        n_full  = r_full;
        we      = 1'b0;
        waddr   = r_count[AW-1:0];
        wdata   = r_value;
        raddr   = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SRCH;
                    n_func  = i_func;
                    n_value = i_value;
                    n_ptr   = '0;
                end
            end
            S_SRCH: begin
                if (r_func == OP_CLEAR) begin
                    n_count = '0;
                    n_ok    = 1'b1;
                    n_full  = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (hit) begin
                    n_full = 1'b0;
                    unique case (r_func)
                        OP_REMOVE: begin
                            n_state = S_SHIFT;
                            n_ptr   = CW'(r_pidx) + CW'(1);
                        end
                        OP_CONTAINS: begin
                            n_ok    = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (more) begin
                    n_pend = 1'b1;
                    n_pidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_ok    = 1'b0;
                    n_full  = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_func == OP_ADD) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_full = 1'b1;
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + CW'(1);
                            n_ok    = 1'b1;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = r_pidx - AW'(1);
                    wdata = rdata;
                end
                if (more) begin
                    n_pend = 1'b1;
                    n_pidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_func  <= n_func;
        r_value <= n_value;
        r_ptr   <= n_ptr;
        r_pidx  <= n_pidx;
        r_ok    <= n_ok;
        r_full  <= n_full;
    end

    assign mcnt_ext       = {{MCNT_W{1'b0}}, r_count};
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_success      = r_ok;
    assign o_full_reject  = r_full;
    assign o_member_count = mcnt_ext[MCNT_W-1:0];

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_fell_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy fell without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("member count above capacity");

    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_reject) |-> (!o_success && r_count == CW'(CAPACITY)))
        else $error("full reject with success or spare room");

endmodule

FILE: tb/insertion_ordered_int_set_tb.sv
// ----------------------------------------------------------------------------
// insertion_ordered_int_set_tb
// Self-checking bench for the insertion-ordered integer set. A short table of
// directed transactions covers the value extremes and every operation,
// including duplicate adds, misses and clears. Random
// transactions follow. They are grouped into fill, drain, mixed and noise
// runs, so that the store is often full and often empty. Every accepted
// transaction is replayed on a local copy of the set, and each result strobe
// is checked against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module insertion_ordered_int_set_tb;
    import iois_pkg::*;

    localparam int SET_CAP    = 64;
    localparam int POOL_SIZE  = 80;
    localparam int RAND_TXNS  = 1900;
    localparam int DRAIN_WAIT = 2 * SET_CAP + 8;
    localparam int N_DIRECTED = 17;

    typedef struct packed {
        logic  success;
        logic  full_reject;
        t_mcnt member_count;
    } t_set_result;

    typedef struct packed {
        t_func       fn;
        t_value      val;
        logic        typed;
        t_set_result exp;
    } t_dir_row;

    typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED, RUN_NOISE} t_run_kind;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_func  i_func;
    t_value i_value;
    logic   o_valid;
    logic   o_success;
    logic   o_full_reject;
    t_mcnt  o_member_count;

    t_value      set_vals [SET_CAP];
    int          set_count;
    t_set_result expected_results [$];
    t_value      value_pool [POOL_SIZE];
    int          mismatches;

    // expectation typed in only where obvious; typed bit clear means predicted
    t_dir_row directed_rows [N_DIRECTED] = '{
        '{OP_CONTAINS, 32'sh00000000, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{OP_REMOVE,   32'sh00000000, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{OP_ADD,      32'sh80000000, 1'b1, '{1'b1, 1'b0, 7'd1}},
        '{OP_ADD,      32'sh7FFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{OP_ADD,      32'sh80000000, 1'b1, '{1'b0, 1'b0, 7'd2}},
        '{OP_CONTAINS, 32'sh7FFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{OP_ADD,      32'sh00000000, 1'b0, '0},
        '{OP_ADD,      32'shFFFFFFFF, 1'b0, '0},
        '{OP_ADD,      32'sh5A5AA5A5, 1'b0, '0},
        '{OP_REMOVE,   32'sh80000000, 1'b0, '0},
        '{OP_CONTAINS, 32'sh80000000, 1'b0, '0},
        '{OP_REMOVE,   32'sh5A5AA5A5, 1'b0, '0},
        '{OP_REMOVE,   32'sh00012345, 1'b0, '0},
        '{OP_CONTAINS, 32'shFFFFFFFF, 1'b0, '0},
        '{OP_CLEAR,    32'shFFFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd0}},
        '{OP_CLEAR,    32'sh00000000, 1'b1, '{1'b1, 1'b0, 7'd0}},
        '{OP_CONTAINS, 32'sh7FFFFFFF, 1'b1, '{1'b0, 1'b0, 7'd0}}
    };

    insertion_ordered_int_set #(
        .CAPACITY(SET_CAP)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_success      (o_success),
        .o_full_reject  (o_full_reject),
        .o_member_count (o_member_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int find_member(input t_value v);
        for (int i = 0; i < set_count; i++) begin
            if (set_vals[i] == v) return i;
        end
        return set_count;
    endfunction

    task automatic apply_set_op(input t_func fn, input t_value v, output t_set_result r);
        int pos;
        pos = find_member(v);
        r   = '0;
        case (fn)
            OP_ADD: begin
                if (pos == set_count) begin
                    if (set_count >= SET_CAP) begin
                        r.full_reject = 1'b1;
                    end else begin
                        set_vals[set_count] = v;
                        set_count++;
                        r.success = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (pos < set_count) begin
                    for (int i = pos; i < set_count - 1; i++) set_vals[i] = set_vals[i + 1];
                    set_count--;
                    r.success = 1'b1;
                end
            end
            OP_CONTAINS: r.success = (pos < set_count);
            default: begin
                set_count = 0;
                r.success = 1'b1;
            end
        endcase
        r.member_count = t_mcnt'(set_count);
    endtask

    // entered just after a falling edge; returns just after a falling edge
    task automatic send_txn(input t_func fn, input t_value v, input int gap,
                            input bit typed, input t_set_result typed_exp);
        t_set_result predicted;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_func  = fn;
        i_value = v;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_set_op(fn, v, predicted);
        expected_results.push_back(typed ? typed_exp : predicted);
        @(negedge i_clk);
    endtask

    function automatic t_value pick_value(input t_run_kind kind, input t_func fn);
        int roll;
        roll = $urandom_range(0, 99);
        if (kind == RUN_NOISE || roll < 12) return t_value'($urandom);
        if (fn == OP_ADD && kind == RUN_FILL && roll < 50) return t_value'($urandom);
        if (fn != OP_ADD && set_count > 0 && roll < 60)
            return set_vals[$urandom_range(0, set_count - 1)];
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_func pick_func(input t_run_kind kind);
        int roll;
        roll = $urandom_range(0, 99);
        case (kind)
            RUN_FILL:  return roll < 75 ? OP_ADD : roll < 90 ? OP_CONTAINS : OP_REMOVE;
            RUN_DRAIN: return roll < 60 ? OP_REMOVE : roll < 80 ? OP_CONTAINS : OP_ADD;
            RUN_MIXED: begin
                if (roll < 3) return OP_CLEAR;
                return roll < 40 ? OP_ADD : roll < 70 ? OP_REMOVE : OP_CONTAINS;
            end
            default: begin
                if (roll < 5) return OP_CLEAR;
                return t_func'($urandom_range(0, 2));
            end
        endcase
    endfunction

    // results cannot be held off, so every strobe is checked on the spot
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: s=%b f=%b n=%0d",
                             o_success, o_full_reject, o_member_count);
            end else begin
                want = expected_results.pop_front();
                if (o_success !== want.success || o_full_reject !== want.full_reject ||
                    o_member_count !== want.member_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp s=%b f=%b n=%0d, got s=%b f=%b n=%0d",
                                 want.success, want.full_reject, want.member_count,
                                 o_success, o_full_reject, o_member_count);
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_run_kind kind;
        int        sent;
        int        run_len;
        bit        no_idle;
        t_func     fn;

        mismatches = 0;
        set_count  = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_func     = OP_ADD;
        i_value    = '0;
        foreach (value_pool[k]) value_pool[k] = t_value'($urandom);
        value_pool[0] = 32'sh80000000;
        value_pool[1] = 32'sh7FFFFFFF;
        value_pool[2] = 32'sh00000000;
        value_pool[3] = 32'shFFFFFFFF;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k])
            send_txn(directed_rows[k].fn, directed_rows[k].val, $urandom_range(0, 10),
                     directed_rows[k].typed, directed_rows[k].exp);

        sent = 0;
        while (sent < RAND_TXNS) begin
            kind    = t_run_kind'($urandom_range(0, 3));
            run_len = $urandom_range(20, 120);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < run_len && sent < RAND_TXNS; n++) begin
                fn = pick_func(kind);
                send_txn(fn, pick_value(kind, fn), no_idle ? 0 : $urandom_range(0, 10),
                         1'b0, '0);
                sent++;
            end
        end
        start = 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
